// ===== rtl/sisstep_pkg.sv =====
// ----------------------------------------------------------------------------
// sisstep_pkg: shared types and constants of the symmetric index-set stepper
// Field widths, request codes and register indexes used by the core and its
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package sisstep_pkg;

   // Storage geometry
   localparam int MAX_ORDER   = 8;
   localparam int INDEX_BITS  = 4;
   localparam int NUMBER_BITS = 20;
   localparam int SET_W       = 32;

   // Derived widths
   localparam int NBITS_W = $clog2(INDEX_BITS + 1);
   localparam int ORD_W   = $clog2(MAX_ORDER + 1);
   localparam int FIDX_W  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

   // Port field widths
   localparam int REQ_TYPE_W = 2;
   localparam int NUM_W      = 20;
   localparam int DIM_W      = 5;
   localparam int ORDER_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;

   // Reset values of the configuration registers
   localparam logic [DIM_W-1:0]   DIM_RESET   = DIM_W'(2);
   localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(2);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ORDER     = CSR_IDX_W'(1);

   // Request codes
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_FORWARD = 2'd0,
      REQ_BACK    = 2'd1,
      REQ_LOAD    = 2'd2,
      REQ_RESTART = 2'd3
   } req_code_type;

   typedef logic [INDEX_BITS-1:0] field_type;
   typedef field_type [MAX_ORDER-1:0] field_vec_type;

endpackage

`default_nettype wire

// ===== rtl/symmetric_index_set_stepper_core.sv =====
// ----------------------------------------------------------------------------
// symmetric_index_set_stepper_core: steps through symmetric tensor components
// Holds one sorted index set and its running number, and answers each request
// word with the set that follows it.
// ----------------------------------------------------------------------------
// Each request word is taken and its response word is registered on the same
// edge, so the core sustains one word per clock while responses are taken;
// the response is valid in the cycle after acceptance. The only loop is the state
// register (index set and number), which the next-state logic closes.
// Requests are held off only while a response waits un-taken.
// The configuration port is always ready; write it only while the core is
// idle. Writing the order register restarts at the all-zero set; writing the
// dimension keeps the stored bits and reinterprets them at the new width.
`default_nettype none

module symmetric_index_set_stepper_core
   import sisstep_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // load_number[19:0], load_indexset[51:20]
   input  wire logic [REQ_TYPE_W-1:0] req_tuser,  // req_type[1:0]
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // component_number[19:0], packed_indices[51:20]
   output logic                       rsp_tlast,  // at_last
   output logic [RSP_USER_W-1:0]      rsp_tuser,  // at_first[0], step_error[1]
   // configuration channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // state and configuration
   logic [DIM_W-1:0]       dim_ff;
   logic [ORDER_W-1:0]     ord_ff;
   logic [NUMBER_BITS-1:0] pos_ff, pos_in;
   logic [SET_W-1:0]       idx_ff, idx_in;

   // response register
   logic                   rsp_valid_ff;
   logic [NUM_W-1:0]       rsp_num_ff, rsp_num_in;
   logic [SET_W-1:0]       rsp_set_ff, rsp_set_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_first_ff, rsp_first_in;
   logic                   rsp_err_ff, rsp_err_in;

   // geometry
   field_type              dimm1;
   field_type              fmask;
   logic [NBITS_W-1:0]     nbits;
   logic [ORD_W-1:0]       ord;
   logic [MAX_ORDER-1:0]   active;
   logic [SET_W-1:0]       used_mask;

   // request fields
   req_code_type           req_code;
   logic [NUM_W-1:0]       load_number;
   logic [SET_W-1:0]       load_indexset;

   logic                   req_fire;
   logic                   csr_fire;

   field_vec_type          cur_f;
   field_vec_type          new_f;
   logic                   err;

   assign req_fire      = req_tvalid && req_tready;
   assign csr_fire      = csr_valid && csr_ready;
   assign req_tready    = !rsp_valid_ff || rsp_tready;
   assign csr_ready     = 1'b1;
   assign req_code      = req_code_type'(req_tuser);
   assign load_number   = req_tdata[NUM_W-1:0];
   assign load_indexset = req_tdata[NUM_W +: SET_W];

   // clamp dimension and order, derive field width and used fields
   always_comb begin
      logic [ORD_W-1:0] ord_c;
      logic [ORD_W-1:0] ord_lim;
      if (dim_ff == '0) begin
         dimm1 = '0;
      end else if (int'(dim_ff) > (1 << INDEX_BITS)) begin
         dimm1 = '1;
      end else begin
         dimm1 = INDEX_BITS'(dim_ff - DIM_W'(1));
      end
      nbits = NBITS_W'(INDEX_BITS);
      for (int n = INDEX_BITS - 1; n >= 1; n--) begin
         if ((dimm1 >> n) == '0) begin
            nbits = NBITS_W'(n);
         end
      end
      fmask = INDEX_BITS'((1 << nbits) - 1);
      if (ord_ff == '0) begin
         ord_c = ORD_W'(1);
      end else if (int'(ord_ff) > MAX_ORDER) begin
         ord_c = ORD_W'(MAX_ORDER);
      end else begin
         ord_c = ORD_W'(ord_ff);
      end
      ord_lim = ORD_W'(1);
      for (int o = 1; o <= MAX_ORDER; o++) begin
         if (o * int'(nbits) <= SET_W) begin
            ord_lim = ORD_W'(o);
         end
      end
      ord = (ord_c < ord_lim) ? ord_c : ord_lim;
      used_mask = '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
         active[i] = (ORD_W'(i) < ord);
         if (active[i]) begin
            used_mask = used_mask | (SET_W'(fmask) << (i * int'(nbits)));
         end
      end
   end

   // unpack the stored set into fields
   always_comb begin
      for (int i = 0; i < MAX_ORDER; i++) begin
         cur_f[i] = INDEX_BITS'(idx_ff >> (i * int'(nbits))) & fmask;
      end
   end

   // next fields and number for one request
   always_comb begin
      logic               found;
      logic [FIDX_W-1:0]  k;
      field_type          above;
      field_type          v;
      logic [SET_W-1:0]   acc;
      found  = 1'b0;
      k      = '0;
      above  = '0;
      v      = '0;
      new_f  = cur_f;
      err    = 1'b0;
      pos_in = pos_ff;
      case (req_code)
         REQ_FORWARD: begin
            // lowest field below the maximum, bump it and copy downwards
            for (int i = 0; i < MAX_ORDER; i++) begin
               if (active[i] && !found && cur_f[i] != dimm1) begin
                  found = 1'b1;
                  k     = FIDX_W'(i);
               end
            end
            v = (cur_f[k] + INDEX_BITS'(1)) & fmask;
            if (found) begin
               for (int i = 0; i < MAX_ORDER; i++) begin
                  if (FIDX_W'(i) <= k) begin
                     new_f[i] = v;
                  end
               end
               pos_in = pos_ff + NUMBER_BITS'(1);
            end else begin
               err = 1'b1;
            end
         end
         REQ_BACK: begin
            // lowest field differing from the one above, drop it, fill below
            for (int i = 0; i < MAX_ORDER; i++) begin
               above = (i + 1 < MAX_ORDER && active[(i + 1) % MAX_ORDER])
                     ? cur_f[(i + 1) % MAX_ORDER] : '0;
               if (active[i] && !found && cur_f[i] != above) begin
                  found = 1'b1;
                  k     = FIDX_W'(i);
               end
            end
            v = (cur_f[k] - INDEX_BITS'(1)) & fmask;
            if (found) begin
               for (int i = 0; i < MAX_ORDER; i++) begin
                  if (FIDX_W'(i) == k) begin
                     new_f[i] = v;
                  end else if (FIDX_W'(i) < k) begin
                     new_f[i] = dimm1;
                  end
               end
               pos_in = pos_ff - NUMBER_BITS'(1);
            end else begin
               err = 1'b1;
            end
         end
         REQ_LOAD: begin
            for (int i = 0; i < MAX_ORDER; i++) begin
               new_f[i] = INDEX_BITS'(load_indexset >> (i * int'(nbits))) & fmask;
            end
            pos_in = NUMBER_BITS'(load_number);
         end
         REQ_RESTART: begin
            new_f  = '0;
            pos_in = '0;
         end
         default: begin
            new_f  = cur_f;
         end
      endcase

      // repack the used fields
      acc = '0;
      for (int i = 0; i < MAX_ORDER; i++) begin
         if (active[i]) begin
            acc = acc | (SET_W'(new_f[i]) << (i * int'(nbits)));
         end
      end
      idx_in = err ? idx_ff : acc;

      // response word
      rsp_last_in  = 1'b1;
      rsp_first_in = 1'b1;
      for (int i = 0; i < MAX_ORDER; i++) begin
         if (active[i] && new_f[i] != dimm1) begin
            rsp_last_in = 1'b0;
         end
         if (active[i] && new_f[i] != '0) begin
            rsp_first_in = 1'b0;
         end
      end
      rsp_num_in = NUM_W'(pos_in);
      rsp_set_in = idx_in & used_mask;
      rsp_err_in = err;
   end

   // hold configuration and stepping state
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
         ord_ff <= ORDER_RESET;
         pos_ff <= '0;
         idx_ff <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_DIMENSION: begin
               dim_ff <= csr_data[DIM_W-1:0];
            end
            CSR_ORDER: begin
               ord_ff <= csr_data[ORDER_W-1:0];
               pos_ff <= '0;
               idx_ff <= '0;
            end
            default: begin
               dim_ff <= dim_ff;
            end
         endcase
      end else if (req_fire) begin
         pos_ff <= pos_in;
         idx_ff <= idx_in;
      end
   end

   // response valid: set on a new word, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_num_ff   <= rsp_num_in;
         rsp_set_ff   <= rsp_set_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_first_ff <= rsp_first_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - NUM_W - SET_W)'(0), rsp_set_ff, rsp_num_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_err_ff, rsp_first_ff};

endmodule

`default_nettype wire

// ===== rtl/sisstep_checker.sv =====
// ----------------------------------------------------------------------------
// sisstep_checker: port-level checks for the symmetric index-set stepper
// Watches the request and response channels and flags responses that break
// the stepping rules.
// ----------------------------------------------------------------------------
`default_nettype none

module sisstep_checker
   import sisstep_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_TYPE_W-1:0] req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   // a stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response word changed");

   // every accepted request gives a response word on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted request gave no response word");

   // a restart lands on the all-zero set with number zero
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == REQ_RESTART |=>
         rsp_tdata == '0 && rsp_tuser[0] && !rsp_tuser[1])
      else $error("restart did not give the all-zero set");

   // a refused step only happens at one of the ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast || rsp_tuser[0])
      else $error("step refused away from both ends");

endmodule

bind symmetric_index_set_stepper_core sisstep_checker u_sisstep_checker (.*);

`default_nettype wire
